>>> hdl/bpfs_pkg.sv
package bpfs_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int MAX_FIELD_BITS = 56;
  localparam int STORE_BYTES    = BUFFER_BYTES + 8;

  localparam int LOC_W   = 15;
  localparam int WIDTH_W = 6;
  localparam int VALUE_W = 56;
  localparam int WIN_W   = 64;
  localparam int WIN_BYTES = WIN_W / 8;

  // Byte index and 8-byte row index taken from a bit location.
  localparam int BASE_W = LOC_W - 3;
  localparam int ROW_W  = BASE_W - 3 + 1;

  // The store is split into 64-bit rows, alternating between two banks,
  // so that the two rows under any window are read in the same cycle.
  localparam int NUM_ROWS   = (STORE_BYTES + WIN_BYTES - 1) / WIN_BYTES;
  localparam int EVEN_DEPTH = (NUM_ROWS + 1) / 2;
  localparam int ODD_DEPTH  = NUM_ROWS / 2;
  localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
  localparam int ODD_AW     = $clog2(ODD_DEPTH);

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [WIN_BYTES-1:0] be_even;
    logic [WIN_BYTES-1:0] be_odd;
    logic [EVEN_AW-1:0]   addr_even;
    logic [ODD_AW-1:0]    addr_odd;
    logic [WIN_W-1:0]     data_even;
    logic [WIN_W-1:0]     data_odd;
  } bank_wr_t;

endpackage

>>> hdl/bpfs_banks.sv
module bpfs_banks (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  logic [bpfs_pkg::EVEN_AW-1:0]      rd_addr_even_i,
  input  logic [bpfs_pkg::ODD_AW-1:0]       rd_addr_odd_i,
  input  bpfs_pkg::bank_wr_t                wr_i,
  output logic [bpfs_pkg::WIN_W-1:0]        rd_even_o,
  output logic [bpfs_pkg::WIN_W-1:0]        rd_odd_o
);
  import bpfs_pkg::*;

  logic [WIN_W-1:0] mem_even [EVEN_DEPTH];
  logic [WIN_W-1:0] mem_odd  [ODD_DEPTH];
  logic [WIN_W-1:0] rd_even_q;
  logic [WIN_W-1:0] rd_odd_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      if (wr_i.be_even[k]) begin
        mem_even[wr_i.addr_even][8*k +: 8] <= wr_i.data_even[8*k +: 8];
      end
    end
    if (rd_en_i) begin
      rd_even_q <= mem_even[rd_addr_even_i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      if (wr_i.be_odd[k]) begin
        mem_odd[wr_i.addr_odd][8*k +: 8] <= wr_i.data_odd[8*k +: 8];
      end
    end
    if (rd_en_i) begin
      rd_odd_q <= mem_odd[rd_addr_odd_i];
    end
  end

  assign rd_even_o = rd_even_q;
  assign rd_odd_o  = rd_odd_q;

endmodule

>>> hdl/bit_packed_field_store.sv
// Bit-packed field store: a byte buffer accessed as fields of 0 to 56 bits
// at any bit location.
// Input channel (in_valid_i/in_ready_o): one beat carries mode_i,
// bit_location_i, field_width_i and write_value_i. A read returns one beat
// on the output channel (out_valid_o/out_ready_i, read_value_o); a write
// returns nothing.
// Each accepted item first reads the two 64-bit rows under the window from
// the two row banks into their output registers; then, while busy_q is set,
// it either loads the result register or writes the merged rows back. A
// new item is not accepted while the previous one is in flight, which is
// the read-modify-write turn of the bank memories. A read result appears on
// out_valid_o when the result register is loaded.
// The input is not accepted while a result waits in the output register
// and the receiver does not take it, so a stalled receiver stops the input
// after at most one more read item.
// Reset clears the control state only; the buffer contents are undefined
// until written, and no clearing pass runs.
module bit_packed_field_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [bpfs_pkg::LOC_W-1:0]      bit_location_i,
  input  logic [bpfs_pkg::WIDTH_W-1:0]    field_width_i,
  input  logic [bpfs_pkg::VALUE_W-1:0]    write_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bpfs_pkg::VALUE_W-1:0]    read_value_o
);
  import bpfs_pkg::*;

  logic in_fire;

  // Request side: row addresses of the window.
  logic [BASE_W-1:0] base_in;
  logic [ROW_W-1:0]  row_lo;
  logic [ROW_W-1:0]  row_hi;
  logic [ROW_W-1:0]  row_even;
  logic [ROW_W-1:0]  row_odd;

  // Item in flight, held while the bank data comes back.
  logic                busy_q;
  logic                s1_write_q;
  logic [BASE_W-1:0]   s1_base_q;
  logic [2:0]          s1_off_q;
  logic [WIDTH_W-1:0]  s1_width_q;
  logic [VALUE_W-1:0]  s1_value_q;
  logic [EVEN_AW-1:0]  s1_addr_even_q;
  logic [ODD_AW-1:0]   s1_addr_odd_q;

  logic                out_valid_q;
  logic                out_valid_d;
  logic [VALUE_W-1:0]  read_value_q;

  logic [WIN_W-1:0]     rd_even;
  logic [WIN_W-1:0]     rd_odd;
  logic [2*WIN_W-1:0]   pair;
  logic [WIN_W-1:0]     win_raw;
  logic [WIN_W-1:0]     win;
  logic [WIN_BYTES-1:0] byte_ok;
  logic [WIDTH_W-1:0]   width_sat;
  logic [WIN_W-1:0]     fmask;
  logic [WIN_W-1:0]     wmask;
  logic [WIN_W-1:0]     win_new;
  logic [WIN_BYTES-1:0] be_win;
  logic [2*WIN_W-1:0]   pair_new;
  logic [2*WIN_BYTES-1:0] be_pair;
  logic [VALUE_W-1:0]   field_val;
  bank_wr_t             bank_wr;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign base_in = bit_location_i[LOC_W-1:3];
  assign row_lo  = {1'b0, base_in[BASE_W-1:3]};
  assign row_hi  = row_lo + ROW_W'(1);
  // The two rows under a window are consecutive, so one is even and one odd.
  assign row_even = row_lo[0] ? row_hi : row_lo;
  assign row_odd  = row_lo[0] ? row_lo : row_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_write_q     <= (mode_i == MODE_WRITE);
      s1_base_q      <= base_in;
      s1_off_q       <= bit_location_i[2:0];
      s1_width_q     <= field_width_i;
      s1_value_q     <= write_value_i;
      s1_addr_even_q <= row_even[EVEN_AW:1];
      s1_addr_odd_q  <= row_odd[ODD_AW:1];
    end
  end

  bpfs_banks u_banks (
    .clk_i          (clk_i),
    .rd_en_i        (in_fire),
    .rd_addr_even_i (row_even[EVEN_AW:1]),
    .rd_addr_odd_i  (row_odd[ODD_AW:1]),
    .wr_i           (bank_wr),
    .rd_even_o      (rd_even),
    .rd_odd_o       (rd_odd)
  );

  // Put the lower-addressed row in the low half, then select the window.
  assign pair    = s1_base_q[3] ? {rd_even, rd_odd} : {rd_odd, rd_even};
  assign win_raw = WIN_W'(pair >> {s1_base_q[2:0], 3'b000});

  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      byte_ok[k] = (32'({1'b0, s1_base_q}) + 32'(k)) < STORE_BYTES;
      win[8*k +: 8] = byte_ok[k] ? win_raw[8*k +: 8] : 8'h00;
    end
  end

  assign width_sat = (s1_width_q > WIDTH_W'(MAX_FIELD_BITS)) ? WIDTH_W'(MAX_FIELD_BITS)
                                                              : s1_width_q;
  assign fmask     = (WIN_W'(1) << width_sat) - WIN_W'(1);
  assign wmask     = fmask << s1_off_q;
  assign field_val = VALUE_W'((win >> s1_off_q) & fmask);
  assign win_new   = (win & ~wmask) | ((WIN_W'(s1_value_q) << s1_off_q) & wmask);

  // Only bytes that the field touches are written back.
  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      be_win[k] = busy_q && s1_write_q && byte_ok[k] && (|wmask[8*k +: 8]);
    end
  end

  assign pair_new = (2*WIN_W)'(win_new) << {s1_base_q[2:0], 3'b000};
  assign be_pair  = (2*WIN_BYTES)'(be_win) << s1_base_q[2:0];

  always_comb begin
    bank_wr.addr_even = s1_addr_even_q;
    bank_wr.addr_odd  = s1_addr_odd_q;
    if (s1_base_q[3]) begin
      bank_wr.data_odd  = pair_new[WIN_W-1:0];
      bank_wr.be_odd    = be_pair[WIN_BYTES-1:0];
      bank_wr.data_even = pair_new[2*WIN_W-1:WIN_W];
      bank_wr.be_even   = be_pair[2*WIN_BYTES-1:WIN_BYTES];
    end else begin
      bank_wr.data_even = pair_new[WIN_W-1:0];
      bank_wr.be_even   = be_pair[WIN_BYTES-1:0];
      bank_wr.data_odd  = pair_new[2*WIN_W-1:WIN_W];
      bank_wr.be_odd    = be_pair[2*WIN_BYTES-1:WIN_BYTES];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (busy_q && !s1_write_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !s1_write_q) begin
      read_value_q <= field_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

  // A result only appears after a read beat was accepted.
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && (mode_i == MODE_READ), 2))
    else $error("result without a preceding read");

  // The output register is always free while an item is in flight.
  a_out_free_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("output register occupied while an item is in flight");

  // No new beat overlaps the read-modify-write of the previous item.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_fire)
    else $error("input accepted on consecutive cycles");

  // Bank writes come only from a write item while it is in flight (busy_q).
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((|bank_wr.be_even) || (|bank_wr.be_odd)) |-> (busy_q && s1_write_q))
    else $error("bank write outside a write item");

endmodule
